// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/blrast_pkg.sv =====
package blrast_pkg;

  localparam int CANVAS_WIDTH_DEF  = 256;
  localparam int CANVAS_HEIGHT_DEF = 64;

  localparam int COORD_W    = 10;
  localparam int CRD_W      = COORD_W + 1;
  localparam int GLYPH_W    = 8;
  localparam int CELL_COL_W = 8;
  localparam int CELL_ROW_W = 6;
  localparam int ERR_W      = COORD_W + 3;

  localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 8'd32;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [GLYPH_W-1:0] glyph;
  } wr_req_t;

  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } rd_req_t;

endpackage

// ===== hdl/bresenham_line_raster.sv =====
// Line rasterizer onto a character canvas held in one synchronous memory.
// Input channel (in_valid_i/in_ready_o): one request per handshake. A draw
// request (action_i = 0) writes glyph_i to every on-canvas point of the
// line between the two signed endpoints and returns nothing. A read request
// (action_i = 1) returns the glyph at (cell_col_i, cell_row_i), or a space
// when the cell lies outside the canvas.
// Output channel (out_valid_o/out_ready_i): read results only, held in an
// output register until taken.
// A read result passes through the canvas read register and then the output
// register. A draw keeps the block busy through the walker's order,
// difference and setup states and then walks N = max(|dx|, |dy|) + 1 points,
// one per cycle through the single write port of the canvas memory.
// Reset: the canvas is filled with spaces by a pass of one entry per cycle
// over all 2^(clog2(CANVAS_WIDTH) + clog2(CANVAS_HEIGHT)) entries (16384 by
// default); in_ready_o stays low during that pass.
// Stall: while a read result waits, a new request is accepted only in the
// cycle in which the waiting result is taken.
module bresenham_line_raster #(
  parameter int CANVAS_WIDTH  = blrast_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = blrast_pkg::CANVAS_HEIGHT_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     action_i,
  input  logic signed [blrast_pkg::COORD_W-1:0]    start_x_i,
  input  logic signed [blrast_pkg::COORD_W-1:0]    start_y_i,
  input  logic signed [blrast_pkg::COORD_W-1:0]    end_x_i,
  input  logic signed [blrast_pkg::COORD_W-1:0]    end_y_i,
  input  logic [blrast_pkg::GLYPH_W-1:0]           glyph_i,
  input  logic [blrast_pkg::CELL_COL_W-1:0]        cell_col_i,
  input  logic [blrast_pkg::CELL_ROW_W-1:0]        cell_row_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [blrast_pkg::GLYPH_W-1:0]           read_glyph_o
);

  blrast_pkg::wr_req_t            wr_req;
  blrast_pkg::rd_req_t            rd_req;
  logic [blrast_pkg::GLYPH_W-1:0] rd_data;
  logic                           clr_busy;
  logic                           walk_busy;
  logic                           in_acc;
  logic                           start_draw;
  logic                           rd_oob;

  logic                           rd_pend_q;
  logic                           oob_q;
  logic                           out_valid_q;
  logic [blrast_pkg::GLYPH_W-1:0] out_data_q;

  assign in_ready_o = !clr_busy && !walk_busy && !rd_pend_q
                   && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign start_draw = in_acc && (action_i == blrast_pkg::ACT_DRAW);

  assign rd_req.en  = in_acc && (action_i == blrast_pkg::ACT_READ);
  assign rd_req.col = blrast_pkg::COORD_W'(cell_col_i);
  assign rd_req.row = blrast_pkg::COORD_W'(cell_row_i);
  assign rd_oob     = (32'(cell_col_i) >= 32'(CANVAS_WIDTH))
                   || (32'(cell_row_i) >= 32'(CANVAS_HEIGHT));

  blrast_walker #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_draw),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i  (end_x_i),
    .end_y_i  (end_y_i),
    .glyph_i  (glyph_i),
    .busy_o   (walk_busy),
    .wr_o     (wr_req)
  );

  blrast_canvas #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) u_canvas (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr_req),
    .rd_i     (rd_req),
    .rd_data_o(rd_data),
    .busy_o   (clr_busy)
  );

  always_ff @(posedge clk_i) begin
    if (rd_req.en) begin
      oob_q <= rd_oob;
    end
    if (rd_pend_q) begin
      out_data_q <= oob_q ? blrast_pkg::SPACE_GLYPH : rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_req.en;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_glyph_o = out_data_q;

endmodule

// ===== hdl/blrast_canvas.sv =====
module blrast_canvas #(
  parameter int CANVAS_WIDTH  = blrast_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = blrast_pkg::CANVAS_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  blrast_pkg::wr_req_t              wr_i,
  input  blrast_pkg::rd_req_t              rd_i,
  output logic [blrast_pkg::GLYPH_W-1:0]   rd_data_o,
  output logic                             busy_o
);

  localparam int XW    = $clog2(CANVAS_WIDTH);
  localparam int YW    = $clog2(CANVAS_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;

  logic [blrast_pkg::GLYPH_W-1:0] mem [DEPTH];
  logic [blrast_pkg::GLYPH_W-1:0] rd_data_q;
  logic                           clr_active_q;
  logic [AW-1:0]                  clr_addr_q;

  logic [AW-1:0]                  wr_addr;
  logic [AW-1:0]                  rd_addr;
  logic [blrast_pkg::GLYPH_W-1:0] wr_data;
  logic                           wr_en;

  // The memory has no reset; a pass after reset fills every entry with spaces.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == {AW{1'b1}}) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  assign wr_en   = clr_active_q | wr_i.en;
  assign wr_addr = clr_active_q ? clr_addr_q : {wr_i.row[YW-1:0], wr_i.col[XW-1:0]};
  assign wr_data = clr_active_q ? blrast_pkg::SPACE_GLYPH : wr_i.glyph;
  assign rd_addr = {rd_i.row[YW-1:0], rd_i.col[XW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_active_q;

endmodule

// ===== hdl/blrast_walker.sv =====
module blrast_walker #(
  parameter int CANVAS_WIDTH  = blrast_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = blrast_pkg::CANVAS_HEIGHT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [blrast_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [blrast_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [blrast_pkg::COORD_W-1:0] end_x_i,
  input  logic signed [blrast_pkg::COORD_W-1:0] end_y_i,
  input  logic [blrast_pkg::GLYPH_W-1:0]        glyph_i,
  output logic                                  busy_o,
  output blrast_pkg::wr_req_t                   wr_o
);

  localparam int CW = blrast_pkg::CRD_W;
  localparam int DW = blrast_pkg::COORD_W;
  localparam int EW = blrast_pkg::ERR_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ORDER = 3'd1;
  localparam logic [2:0] ST_DIFF  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;

  logic [2:0] state_q, state_d;

  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [blrast_pkg::GLYPH_W-1:0] glyph_q;
  logic [DW-1:0]        adx_q, ady_q;
  logic                 dneg_q;
  logic signed [CW-1:0] m_q, m_end_q, n_q;
  logic                 steep_q;
  logic signed [EW-1:0] err_q, k1_q, k2_q;

  logic signed [CW-1:0] dy;
  logic                 shallow;
  logic [DW-1:0]        dm, dn;
  logic signed [EW-1:0] dn2, dm1;
  logic signed [CW-1:0] px, py;
  logic                 on_canvas;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_ORDER;
      ST_ORDER: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SETUP;
      ST_SETUP: state_d = ST_WALK;
      ST_WALK:  if (m_q == m_end_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign dy      = by_q - ay_q;
  assign shallow = ady_q < adx_q;
  assign dm      = shallow ? adx_q : ady_q;
  assign dn      = shallow ? ady_q : adx_q;
  assign dn2     = $signed({2'b00, dn, 1'b0});
  assign dm1     = $signed({3'b000, dm});

  // The walk always steps up the major axis; the minor axis moves down
  // exactly when the ordered line falls in y.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ax_q    <= {start_x_i[DW-1], start_x_i};
          ay_q    <= {start_y_i[DW-1], start_y_i};
          bx_q    <= {end_x_i[DW-1], end_x_i};
          by_q    <= {end_y_i[DW-1], end_y_i};
          glyph_q <= glyph_i;
        end
      end
      ST_ORDER: begin
        if (ax_q > bx_q) begin
          ax_q <= bx_q;
          ay_q <= by_q;
          bx_q <= ax_q;
          by_q <= ay_q;
        end
      end
      ST_DIFF: begin
        adx_q  <= DW'(bx_q - ax_q);
        dneg_q <= dy[CW-1];
        ady_q  <= dy[CW-1] ? DW'(ay_q - by_q) : DW'(dy);
      end
      ST_SETUP: begin
        steep_q <= !shallow;
        if (shallow) begin
          m_q     <= ax_q;
          m_end_q <= bx_q;
          n_q     <= ay_q;
        end else if (dneg_q) begin
          m_q     <= by_q;
          m_end_q <= ay_q;
          n_q     <= bx_q;
        end else begin
          m_q     <= ay_q;
          m_end_q <= by_q;
          n_q     <= ax_q;
        end
        k1_q  <= dn2;
        k2_q  <= dn2 - (dm1 <<< 1);
        err_q <= dn2 - dm1;
      end
      ST_WALK: begin
        m_q <= m_q + CW'(1);
        if (err_q > 0) begin
          n_q   <= dneg_q ? n_q - CW'(1) : n_q + CW'(1);
          err_q <= err_q + k2_q;
        end else begin
          err_q <= err_q + k1_q;
        end
      end
      default: begin
        m_q <= m_q;
      end
    endcase
  end

  assign px = steep_q ? n_q : m_q;
  assign py = steep_q ? m_q : n_q;

  assign on_canvas = !px[CW-1] && !py[CW-1]
                  && (32'(px[CW-2:0]) < 32'(CANVAS_WIDTH))
                  && (32'(py[CW-2:0]) < 32'(CANVAS_HEIGHT));

  assign wr_o.en    = (state_q == ST_WALK) && on_canvas;
  assign wr_o.col   = px[DW-1:0];
  assign wr_o.row   = py[DW-1:0];
  assign wr_o.glyph = glyph_q;
  assign busy_o     = (state_q != ST_IDLE);

endmodule

// ===== hdl/blrast_checker.sv =====
`include "assert_macros.svh"

module blrast_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           action_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [blrast_pkg::GLYPH_W-1:0] read_glyph_o
);

  logic rd_acc;
  logic draw_acc;
  logic out_stall;

  assign rd_acc    = in_valid_i && in_ready_o && (action_i == blrast_pkg::ACT_READ);
  assign draw_acc  = in_valid_i && in_ready_o && (action_i == blrast_pkg::ACT_DRAW);
  assign out_stall = out_valid_o && !out_ready_i;

  // A waiting result holds its value until it is taken.
  `ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(read_glyph_o), "result lost in stall")

  // A read result follows the canvas read and output registers.
  `ASSERT_IMPL(a_read_latency, rd_acc, ##2 out_valid_o, "read result missing")

  // No new request is taken while a stalled result blocks the output.
  `ASSERT_IMPL(a_no_accept_stalled, out_stall, !in_ready_o, "request taken while stalled")

  // Both a read and a draw occupy the block in the following cycle.
  `ASSERT_NEXT(a_busy_after_req, rd_acc || draw_acc, !in_ready_o, "ready right after a request")

endmodule

bind bresenham_line_raster blrast_checker u_blrast_checker (.*);
